// ----- rtl/socr_pkg.sv -----
// shared constants and types for the scan-order slot replacement block
`timescale 1ns / 1ps
package socr_pkg;
    localparam int SLOTS       = 256;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int LINK_W      = IDX_W + 1;
    localparam int OFFSET_BITS = 32;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [OFFSET_BITS-1:0] off_t;

    // one entry of the sorted list, held by one cell
    typedef struct packed {
        logic  used;
        off_t  off;
        link_t nxt;
        link_t prv;
    } entry_t;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic  we;
        logic  [IDX_W-1:0] idx;
        logic  set_off;
        off_t  off;
        logic  set_nxt;
        link_t nxt;
        logic  set_prv;
        link_t prv;
    } cell_cmd_t;
endpackage

// ----- rtl/socr_cell.sv -----
// one list cell: holds offset and links of a slot and shifts a read tap
`timescale 1ns / 1ps
module socr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               [socr_pkg::IDX_W-1:0] my_idx,
    input  socr_pkg::cell_cmd_t cmd,
    input  socr_pkg::entry_t   tap_in,
    input  logic               load,
    output socr_pkg::entry_t   tap_out,
    output socr_pkg::entry_t   entry
);
    import socr_pkg::*;

    logic   used_reg;
    off_t   off_reg;
    link_t  nxt_reg;
    link_t  prv_reg;
    entry_t tap_reg;
    logic   hit;

    assign hit = cmd.we && (cmd.idx == my_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            nxt_reg  <= NIL;
            prv_reg  <= NIL;
        end
        else if (hit)
        begin
            used_reg <= 1'b1;
            if (cmd.set_nxt)
            begin
                nxt_reg <= cmd.nxt;
            end
            if (cmd.set_prv)
            begin
                prv_reg <= cmd.prv;
            end
        end
    end

    // offset is payload: no reset
    always_ff @(posedge clk)
    begin
        if (hit && cmd.set_off)
        begin
            off_reg <= cmd.off;
        end
    end

    // shift tap: load captures own entry, otherwise pass neighbor's value
    always_ff @(posedge clk)
    begin
        tap_reg <= load ? entry : tap_in;
    end

    assign tap_out = tap_reg;
    assign entry   = {used_reg, off_reg, nxt_reg, prv_reg};
endmodule

// ----- rtl/scan_order_cache_replacement.sv -----
// top level: scan-order cache slot replacement over a chain of list cells
`timescale 1ns / 1ps
// channel | signals                                   | dir
// request | req_valid, req_ready, request_offset      | in
// result  | res_valid, res_ready, slot, evicted,
//         | victim_slot, victim_offset                | out
//
// a request with free slots runs: snapshot load, chain scan over every entry,
// place, up to 2 link writes, done; a full cache adds evict and unlink first.
// the scan length is fixed, so the list walk bounds every request.
// reset clears all links, head, scan pointer and fill count at once.
// the result sits in its own output register; the next request is taken
// right after done, and done waits only while an older result is unaccepted.
module scan_order_cache_replacement (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  logic [31:0] request_offset,
    output logic res_valid,
    input  logic res_ready,
    output logic [7:0]  slot,
    output logic evicted,
    output logic [7:0]  victim_slot,
    output logic [31:0] victim_offset
);
    import socr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVICT = 4'd1;
    localparam logic [3:0] S_UNLNK = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_PLACE = 4'd5;
    localparam logic [3:0] S_LINK1 = 4'd6;
    localparam logic [3:0] S_LINK2 = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // ---- cell chain ----
    cell_cmd_t cmd;
    entry_t    ent   [SLOTS];
    entry_t    tap   [SLOTS+1];
    logic      load;

    // ---- control registers ----
    logic [3:0]  state_reg, state_next;
    link_t       head_reg, head_next;
    link_t       scan_reg, scan_next;
    logic [LINK_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] s_reg, s_next;    // slot being placed, also read address
    off_t        off_reg, off_next;
    logic        ev_reg, ev_next;
    off_t        voff_reg, voff_next;
    entry_t      rd_reg;                // registered read of the slot at s
    logic [IDX_W-1:0] j_reg, j_next;    // index of the entry at the chain tap
    logic        le_any_reg, le_any_next;
    link_t       x_idx_reg, x_idx_next;
    link_t       x_prv_reg, x_prv_next;
    link_t       x_nxt_reg, x_nxt_next;
    link_t       aft_reg, aft_next;     // old successor of the new slot
    logic        res_valid_reg, res_valid_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic        res_ev_reg, res_ev_next;
    off_t        res_voff_reg, res_voff_next;

    entry_t tap0;
    link_t  vic;
    link_t  s_lnk;
    link_t  m_lnk;
    link_t  after_lnk;

    assign tap[SLOTS] = '0;
    assign load = (state_reg == S_LOAD);
    assign tap0 = tap[0];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            socr_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .my_idx  (IDX_W'(g)),
                .cmd     (cmd),
                .tap_in  (tap[g+1]),
                .load    (load),
                .tap_out (tap[g]),
                .entry   (ent[g])
            );
        end
    endgenerate

    function automatic logic vld(input link_t l);
        return l < NIL;
    endfunction

    // victim: scan pointer, else head, else slot 0
    assign vic   = vld(scan_reg) ? scan_reg : (vld(head_reg) ? head_reg : '0);
    assign s_lnk = {1'b0, s_reg};

    // entries with offset <= new one form a list prefix ending at m:
    // xor of their indexes against their prev links leaves m and null,
    // against their next links leaves the head and m's successor
    assign m_lnk     = x_idx_reg ^ x_prv_reg ^ NIL;
    assign after_lnk = x_idx_reg ^ x_nxt_reg ^ head_reg;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        used_next      = used_reg;
        s_next         = s_reg;
        off_next       = off_reg;
        ev_next        = ev_reg;
        voff_next      = voff_reg;
        j_next         = j_reg;
        le_any_next    = le_any_reg;
        x_idx_next     = x_idx_reg;
        x_prv_next     = x_prv_reg;
        x_nxt_next     = x_nxt_reg;
        aft_next       = aft_reg;
        res_valid_next = res_valid_reg;
        res_slot_next  = res_slot_reg;
        res_ev_next    = res_ev_reg;
        res_voff_next  = res_voff_reg;
        cmd            = '0;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    off_next = request_offset;
                    if (used_reg < NIL)
                    begin
                        s_next     = used_reg[IDX_W-1:0];
                        used_next  = used_reg + LINK_W'(1);
                        ev_next    = 1'b0;
                        voff_next  = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        // victim entry is read into rd_reg at this edge
                        s_next     = vic[IDX_W-1:0];
                        ev_next    = 1'b1;
                        state_next = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                voff_next = rd_reg.off;
                if (s_lnk == head_reg)
                begin
                    head_next = rd_reg.nxt;
                end
                scan_next = vld(rd_reg.nxt) ? rd_reg.nxt :
                            ((s_lnk == head_reg) ? rd_reg.nxt : head_reg);
                // patch predecessor's next link
                if (vld(rd_reg.prv))
                begin
                    cmd.we      = 1'b1;
                    cmd.idx     = rd_reg.prv[IDX_W-1:0];
                    cmd.set_nxt = 1'b1;
                    cmd.nxt     = rd_reg.nxt;
                end
                state_next = S_UNLNK;
            end
            S_UNLNK:
            begin
                // patch successor's prev link
                if (vld(rd_reg.nxt))
                begin
                    cmd.we      = 1'b1;
                    cmd.idx     = rd_reg.nxt[IDX_W-1:0];
                    cmd.set_prv = 1'b1;
                    cmd.prv     = rd_reg.prv;
                end
                if (scan_reg == s_lnk)
                begin
                    scan_next = head_reg;
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // every cell copies its entry into its tap at this edge
                j_next      = '0;
                le_any_next = 1'b0;
                x_idx_next  = '0;
                x_prv_next  = '0;
                x_nxt_next  = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                // entry j arrives at the chain end; the slot being placed is skipped
                if (tap0.used && (j_reg != s_reg) && (tap0.off <= off_reg))
                begin
                    le_any_next = 1'b1;
                    x_idx_next  = x_idx_reg ^ {1'b0, j_reg};
                    x_prv_next  = x_prv_reg ^ tap0.prv;
                    x_nxt_next  = x_nxt_reg ^ tap0.nxt;
                end
                if (j_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_PLACE:
            begin
                cmd.we = 1'b1; cmd.idx = s_reg;
                cmd.set_off = 1'b1; cmd.off = off_reg;
                cmd.set_nxt = 1'b1;
                cmd.set_prv = 1'b1;
                if (!vld(head_reg))
                begin
                    // empty list
                    cmd.nxt    = NIL;
                    cmd.prv    = NIL;
                    head_next  = s_lnk;
                    scan_next  = s_lnk;
                    state_next = S_DONE;
                end
                else if (!le_any_reg)
                begin
                    // new smallest: becomes head, scan pointer stays
                    cmd.nxt    = head_reg;
                    cmd.prv    = NIL;
                    aft_next   = head_reg;
                    head_next  = s_lnk;
                    state_next = S_LINK2;
                end
                else
                begin
                    cmd.nxt    = after_lnk;
                    cmd.prv    = m_lnk;
                    aft_next   = after_lnk;
                    state_next = S_LINK1;
                end
            end
            S_LINK1:
            begin
                // m.next = s
                cmd.we = 1'b1; cmd.idx = m_lnk[IDX_W-1:0];
                cmd.set_nxt = 1'b1; cmd.nxt = s_lnk;
                state_next = vld(aft_reg) ? S_LINK2 : S_DONE;
            end
            S_LINK2:
            begin
                // old successor or old head: prev = s
                cmd.we = 1'b1; cmd.idx = aft_reg[IDX_W-1:0];
                cmd.set_prv = 1'b1; cmd.prv = s_lnk;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait here while an older result is still held
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_slot_next  = s_reg;
                    res_ev_next    = ev_reg;
                    res_voff_next  = voff_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            scan_reg      <= NIL;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            scan_reg      <= scan_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        off_reg      <= off_next;
        ev_reg       <= ev_next;
        voff_reg     <= voff_next;
        rd_reg       <= ent[s_next];
        j_reg        <= j_next;
        le_any_reg   <= le_any_next;
        x_idx_reg    <= x_idx_next;
        x_prv_reg    <= x_prv_next;
        x_nxt_reg    <= x_nxt_next;
        aft_reg      <= aft_next;
        res_slot_reg <= res_slot_next;
        res_ev_reg   <= res_ev_next;
        res_voff_reg <= res_voff_next;
    end

    assign res_valid     = res_valid_reg;
    assign slot          = 8'(res_slot_reg);
    assign evicted       = res_ev_reg;
    assign victim_slot   = res_ev_reg ? 8'(res_slot_reg) : 8'd0;
    assign victim_offset = res_ev_reg ? 32'(res_voff_reg) : 32'd0;

    // ---- checks ----
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("request taken while busy");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NIL)
        else $error("fill count out of range");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped before accept");
endmodule
